// ===== rtl/prim_asm_pkg.sv =====
// ----------------------------------------------------------------------------
// Primitive assembler package
// Shared codes, sizes and the job control type for the primitive assembler.
// ----------------------------------------------------------------------------
package prim_asm_pkg;

  localparam int VID_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH      = 4;
  localparam int JOB_VERTS        = 6;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_VERTEX = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  localparam logic [3:0] MODE_POINTS     = 4'd0;
  localparam logic [3:0] MODE_LINES      = 4'd1;
  localparam logic [3:0] MODE_LINE_LOOP  = 4'd2;
  localparam logic [3:0] MODE_LINE_STRIP = 4'd3;
  localparam logic [3:0] MODE_TRIANGLES  = 4'd4;
  localparam logic [3:0] MODE_TRI_STRIP  = 4'd5;
  localparam logic [3:0] MODE_TRI_FAN    = 4'd6;
  localparam logic [3:0] MODE_QUADS      = 4'd7;
  localparam logic [3:0] MODE_QUAD_STRIP = 4'd8;
  localparam logic [3:0] MODE_POLYGON    = 4'd9;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_LINE  = 2'd2;
  localparam logic [1:0] KIND_TRI   = 2'd3;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_INV_OP  = 2'd1;
  localparam logic [1:0] ERR_INV_MODE = 2'd2;

  localparam logic [3:0] PHASE_LAST = 4'd11;

  typedef struct packed {
    logic       two;
    logic [1:0] kind;
    logic [1:0] err;
  } job_ctrl_t;

  localparam int JOB_CTRL_BITS = $bits(job_ctrl_t);

endpackage

// ===== rtl/prim_asm_fifo.sv =====
// ----------------------------------------------------------------------------
// Primitive assembler job queue
// A short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module prim_asm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    store [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = store[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/prim_asm_front.sv =====
// ----------------------------------------------------------------------------
// Primitive assembler front end
// Accepts begin, vertex and end transactions, tracks the batch state and the
// vertex window, and forms a job of up to two results for the queue.
// ----------------------------------------------------------------------------
module prim_asm_front
  import prim_asm_pkg::*;
#(
  parameter int VERTEX_ID_BITS = VID_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      op,
  input  logic [3:0]                      mode,
  input  logic [VERTEX_ID_BITS-1:0]       vertex_id,
  output logic                            job_valid,
  input  logic                            job_ready,
  output job_ctrl_t                       job_ctrl,
  output logic [JOB_VERTS*VERTEX_ID_BITS-1:0] job_verts
);

  typedef logic [VERTEX_ID_BITS-1:0] vid_t;

  function automatic logic [1:0] mod3(input logic [3:0] p);
    logic [1:0] r;
    case (p)
      4'd0, 4'd3, 4'd6, 4'd9:   r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10:  r = 2'd1;
      4'd2, 4'd5, 4'd8, 4'd11:  r = 2'd2;
      default:                  r = 2'd0;
    endcase
    return r;
  endfunction

  logic       batch_active;
  logic [3:0] batch_mode;
  logic [3:0] vertex_phase;
  logic       seen_two;
  logic       winding_parity;
  vid_t       recent [4];
  vid_t       hub_vertex;

  logic       batch_active_next;
  logic [3:0] batch_mode_next;
  logic [3:0] vertex_phase_next;
  logic       seen_two_next;
  logic       winding_parity_next;
  vid_t       recent_next [4];
  vid_t       hub_vertex_next;

  logic       has_result;
  logic       first;
  logic       second;
  logic       accept;
  vid_t       ra0, rb0, rc0, ra1, rb1, rc1;
  vid_t       t [4];

  assign in_ready  = job_ready;
  assign accept    = in_valid && in_ready;
  assign job_valid = in_valid && has_result;
  assign job_verts = {ra0, rb0, rc0, ra1, rb1, rc1};
  assign first     = (vertex_phase == 4'd0) && !seen_two;
  assign second    = (vertex_phase == 4'd1) && !seen_two;

  always_comb begin
    batch_active_next   = batch_active;
    batch_mode_next     = batch_mode;
    vertex_phase_next   = vertex_phase;
    seen_two_next       = seen_two;
    winding_parity_next = winding_parity;
    hub_vertex_next     = hub_vertex;
    for (int i = 0; i < 4; i++) begin
      t[i] = recent[i];
    end
    has_result    = 1'b0;
    job_ctrl.two  = 1'b0;
    job_ctrl.kind = KIND_NONE;
    job_ctrl.err  = ERR_NONE;
    ra0 = '0; rb0 = '0; rc0 = '0;
    ra1 = '0; rb1 = '0; rc1 = '0;

    case (op)
      OP_BEGIN: begin
        if (batch_active) begin
          has_result   = 1'b1;
          job_ctrl.err = ERR_INV_OP;
        end else if (mode > MODE_POLYGON) begin
          has_result   = 1'b1;
          job_ctrl.err = ERR_INV_MODE;
        end else begin
          batch_active_next   = 1'b1;
          batch_mode_next     = mode;
          vertex_phase_next   = '0;
          seen_two_next       = 1'b0;
          winding_parity_next = 1'b0;
        end
      end
      OP_VERTEX: begin
        if (!batch_active) begin
          has_result   = 1'b1;
          job_ctrl.err = ERR_INV_OP;
        end else begin
          case (batch_mode)
            MODE_POINTS: begin
              has_result    = 1'b1;
              job_ctrl.kind = KIND_POINT;
              ra0           = vertex_id;
            end
            MODE_LINES: begin
              t[{1'b0, vertex_phase[0]}] = vertex_id;
              if (vertex_phase[0]) begin
                has_result    = 1'b1;
                job_ctrl.kind = KIND_LINE;
                ra0 = t[0];
                rb0 = t[1];
              end
            end
            MODE_LINE_LOOP, MODE_LINE_STRIP: begin
              if (first) begin
                if (batch_mode == MODE_LINE_LOOP) begin
                  hub_vertex_next = vertex_id;
                end
              end else begin
                has_result    = 1'b1;
                job_ctrl.kind = KIND_LINE;
                ra0 = recent[0];
                rb0 = vertex_id;
              end
              t[0] = vertex_id;
            end
            MODE_TRIANGLES: begin
              t[mod3(vertex_phase)] = vertex_id;
              if (mod3(vertex_phase) == 2'd2) begin
                has_result    = 1'b1;
                job_ctrl.kind = KIND_TRI;
                ra0 = t[0];
                rb0 = t[1];
                rc0 = t[2];
              end
            end
            MODE_TRI_STRIP: begin
              if (!seen_two) begin
                t[{1'b0, vertex_phase[0]}] = vertex_id;
              end else begin
                has_result    = 1'b1;
                job_ctrl.kind = KIND_TRI;
                ra0 = winding_parity ? recent[1] : recent[0];
                rb0 = winding_parity ? recent[0] : recent[1];
                rc0 = vertex_id;
                winding_parity_next = !winding_parity;
                t[0] = recent[1];
                t[1] = vertex_id;
              end
            end
            MODE_TRI_FAN, MODE_POLYGON: begin
              if (first) begin
                hub_vertex_next = vertex_id;
              end else if (second) begin
                t[0] = vertex_id;
              end else begin
                has_result    = 1'b1;
                job_ctrl.kind = KIND_TRI;
                ra0 = hub_vertex;
                rb0 = recent[0];
                rc0 = vertex_id;
                t[0] = vertex_id;
              end
            end
            MODE_QUADS: begin
              t[vertex_phase[1:0]] = vertex_id;
              if (vertex_phase[1:0] == 2'd3) begin
                has_result    = 1'b1;
                job_ctrl.two  = 1'b1;
                job_ctrl.kind = KIND_TRI;
                ra0 = t[0]; rb0 = t[1]; rc0 = t[2];
                ra1 = t[0]; rb1 = t[2]; rc1 = t[3];
              end
            end
            MODE_QUAD_STRIP: begin
              if (!seen_two) begin
                t[{1'b0, vertex_phase[0]}] = vertex_id;
              end else begin
                t[{1'b1, vertex_phase[0]}] = vertex_id;
                if (vertex_phase[0]) begin
                  has_result    = 1'b1;
                  job_ctrl.two  = 1'b1;
                  job_ctrl.kind = KIND_TRI;
                  ra0 = t[0]; rb0 = t[1]; rc0 = t[3];
                  ra1 = t[0]; rb1 = t[3]; rc1 = t[2];
                  t[0] = t[2];
                  t[1] = t[3];
                end
              end
            end
            default: begin
            end
          endcase
          if (!first) begin
            seen_two_next = 1'b1;
          end
          vertex_phase_next = (vertex_phase == PHASE_LAST) ? '0 : vertex_phase + 1'b1;
        end
      end
      OP_END: begin
        if (!batch_active) begin
          has_result   = 1'b1;
          job_ctrl.err = ERR_INV_OP;
        end else begin
          if ((batch_mode == MODE_LINE_LOOP) && seen_two) begin
            has_result    = 1'b1;
            job_ctrl.kind = KIND_LINE;
            ra0 = recent[0];
            rb0 = hub_vertex;
          end
          batch_active_next = 1'b0;
          vertex_phase_next = '0;
          seen_two_next     = 1'b0;
        end
      end
      default: begin
      end
    endcase

    for (int i = 0; i < 4; i++) begin
      recent_next[i] = t[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_active   <= 1'b0;
      batch_mode     <= '0;
      vertex_phase   <= '0;
      seen_two       <= 1'b0;
      winding_parity <= 1'b0;
    end else if (accept) begin
      batch_active   <= batch_active_next;
      batch_mode     <= batch_mode_next;
      vertex_phase   <= vertex_phase_next;
      seen_two       <= seen_two_next;
      winding_parity <= winding_parity_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) begin
        recent[i] <= recent_next[i];
      end
      hub_vertex <= hub_vertex_next;
    end
  end

endmodule

// ===== rtl/prim_asm_back.sv =====
// ----------------------------------------------------------------------------
// Primitive assembler back end
// Takes jobs from the queue and delivers their one or two results through
// an output register, marking the final result of each job.
// ----------------------------------------------------------------------------
module prim_asm_back
  import prim_asm_pkg::*;
#(
  parameter int VERTEX_ID_BITS = VID_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  output logic                                job_ready,
  input  job_ctrl_t                           job_ctrl,
  input  logic [JOB_VERTS*VERTEX_ID_BITS-1:0] job_verts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          prim_kind,
  output logic [VERTEX_ID_BITS-1:0]           vert_a,
  output logic [VERTEX_ID_BITS-1:0]           vert_b,
  output logic [VERTEX_ID_BITS-1:0]           vert_c,
  output logic [1:0]                          error_code,
  output logic                                last
);

  localparam int VB = VERTEX_ID_BITS;

  logic                         busy;
  logic                         sub;
  job_ctrl_t                    ctrl;
  logic [JOB_VERTS*VB-1:0]      verts;
  logic                         final_result;
  logic                         take;

  assign final_result = !ctrl.two || sub;
  assign take         = out_valid && out_ready;
  assign job_ready    = !busy || (take && final_result);

  assign out_valid  = busy;
  assign last       = final_result;
  assign prim_kind  = sub ? KIND_TRI : ctrl.kind;
  assign error_code = sub ? ERR_NONE : ctrl.err;
  assign vert_a     = sub ? verts[3*VB-1:2*VB] : verts[6*VB-1:5*VB];
  assign vert_b     = sub ? verts[2*VB-1:VB]   : verts[5*VB-1:4*VB];
  assign vert_c     = sub ? verts[VB-1:0]      : verts[4*VB-1:3*VB];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sub  <= 1'b0;
    end else if (job_valid && job_ready) begin
      busy <= 1'b1;
      sub  <= 1'b0;
    end else if (take) begin
      if (final_result) begin
        busy <= 1'b0;
        sub  <= 1'b0;
      end else begin
        sub <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      ctrl  <= job_ctrl;
      verts <= job_verts;
    end
  end

endmodule

// ===== rtl/primitive_assembler_core.sv =====
// ----------------------------------------------------------------------------
// Primitive assembler core
// Assembles points, lines and triangles from begin, vertex and end
// transactions for the ten GL primitive modes.
//
//   Channel   Handshake              Fields
//   input     in_valid / in_ready    op, mode, vertex_id
//   output    out_valid / out_ready  prim_kind, vert_a, vert_b, vert_c,
//                                    error_code, last
//
// One input transaction is accepted per cycle while the job queue has room;
// the front end updates the batch state in that cycle and queues a job of
// up to two results. A result passes through the job queue and the back
// end's output register before it is presented; quads and quad strips
// deliver two results per job.
// Input stalls only when the four-entry job queue is full.
// Reset clears the batch state, the queue and the output register at once.
// ----------------------------------------------------------------------------
module primitive_assembler_core
  import prim_asm_pkg::*;
#(
  parameter int VERTEX_ID_BITS = VID_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                op,
  input  logic [3:0]                mode,
  input  logic [VERTEX_ID_BITS-1:0] vertex_id,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                prim_kind,
  output logic [VERTEX_ID_BITS-1:0] vert_a,
  output logic [VERTEX_ID_BITS-1:0] vert_b,
  output logic [VERTEX_ID_BITS-1:0] vert_c,
  output logic [1:0]                error_code,
  output logic                      last
);

  localparam int VERT_BITS = JOB_VERTS * VERTEX_ID_BITS;
  localparam int JOB_BITS  = JOB_CTRL_BITS + VERT_BITS;

  logic                 push_valid;
  logic                 push_ready;
  job_ctrl_t            push_ctrl;
  logic [VERT_BITS-1:0] push_verts;
  logic                 pop_valid;
  logic                 pop_ready;
  logic [JOB_BITS-1:0]  pop_data;
  job_ctrl_t            pop_ctrl;
  logic [VERT_BITS-1:0] pop_verts;

  assign pop_ctrl  = job_ctrl_t'(pop_data[JOB_BITS-1:VERT_BITS]);
  assign pop_verts = pop_data[VERT_BITS-1:0];

  prim_asm_front #(
    .VERTEX_ID_BITS(VERTEX_ID_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .mode      (mode),
    .vertex_id (vertex_id),
    .job_valid (push_valid),
    .job_ready (push_ready),
    .job_ctrl  (push_ctrl),
    .job_verts (push_verts)
  );

  prim_asm_fifo #(
    .WIDTH(JOB_BITS),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_ctrl, push_verts}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  prim_asm_back #(
    .VERTEX_ID_BITS(VERTEX_ID_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (pop_valid),
    .job_ready  (pop_ready),
    .job_ctrl   (pop_ctrl),
    .job_verts  (pop_verts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .prim_kind  (prim_kind),
    .vert_a     (vert_a),
    .vert_b     (vert_b),
    .vert_c     (vert_c),
    .error_code (error_code),
    .last       (last)
  );

endmodule

// ===== tb/primitive_assembler_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Primitive assembler core testbench
// Drives begin, vertex and end transactions into the assembler and checks each
// emitted primitive against an in-bench assembly model. A short scripted
// sequence covers errors, extremes and closing lines. Random batches in all
// ten modes follow, with idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module primitive_assembler_core_tb;
  import prim_asm_pkg::*;

  localparam int VW = VID_BITS_DEFAULT;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int ITEM_TARGET = 1825;
  localparam int CALM_FROM = 1600;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [1:0]    kind;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
    logic [VW-1:0] c;
    logic [1:0]    err;
    logic          last;
  } prim_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [3:0]    mode;
    logic [VW-1:0] vid;
    logic          typed;
    prim_t         want;
  } row_t;

  localparam prim_t BAD_OP_RESULT = '{KIND_NONE, '0, '0, '0, ERR_INV_OP, 1'b1};
  localparam prim_t BAD_MODE_RESULT = '{KIND_NONE, '0, '0, '0, ERR_INV_MODE, 1'b1};

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [1:0]    op = OP_BEGIN;
  logic [3:0]    mode = MODE_POINTS;
  logic [VW-1:0] vertex_id = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [1:0]    prim_kind;
  logic [VW-1:0] vert_a;
  logic [VW-1:0] vert_b;
  logic [VW-1:0] vert_c;
  logic [1:0]    error_code;
  logic          last;

  prim_t expected_prims[$];
  prim_t fresh_prims[$];
  int    mismatches = 0;
  int    items_sent = 0;
  int    stall_left = 0;
  int    quiet_cycles = 0;
  bit    tx_idles = 1'b1;
  bit    rx_stalls = 1'b1;

  logic          asm_open = 1'b0;
  logic [3:0]    asm_mode = MODE_POINTS;
  logic [3:0]    asm_phase = '0;
  logic          asm_two = 1'b0;
  logic          asm_odd = 1'b0;
  logic [VW-1:0] asm_win [4] = '{default: '0};
  logic [VW-1:0] asm_hub = '0;

  row_t dir_rows [25] = '{
    '{OP_VERTEX, MODE_POINTS, 16'hFFFF, 1'b1, BAD_OP_RESULT},
    '{OP_END, MODE_POINTS, 16'h0000, 1'b1, BAD_OP_RESULT},
    '{OP_BEGIN, 4'd15, 16'h0000, 1'b1, BAD_MODE_RESULT},
    '{OP_BEGIN, 4'd10, 16'h0000, 1'b1, BAD_MODE_RESULT},
    '{OP_SPARE, 4'd10, 16'hA5A5, 1'b0, '0},
    '{OP_BEGIN, MODE_POINTS, 16'h0000, 1'b0, '0},
    '{OP_VERTEX, MODE_POINTS, 16'h0000, 1'b1, '{KIND_POINT, '0, '0, '0, ERR_NONE, 1'b1}},
    '{OP_VERTEX, MODE_POINTS, 16'hFFFF, 1'b1, '{KIND_POINT, '1, '0, '0, ERR_NONE, 1'b1}},
    '{OP_BEGIN, MODE_TRIANGLES, 16'h0000, 1'b1, BAD_OP_RESULT},
    '{OP_SPARE, 4'd5, 16'h5A5A, 1'b0, '0},
    '{OP_END, MODE_POINTS, 16'h0000, 1'b0, '0},
    '{OP_BEGIN, MODE_LINE_LOOP, 16'h0000, 1'b0, '0},
    '{OP_VERTEX, MODE_POINTS, 16'h1234, 1'b0, '0},
    '{OP_END, MODE_POINTS, 16'h0000, 1'b0, '0},
    '{OP_BEGIN, MODE_LINE_LOOP, 16'h0000, 1'b0, '0},
    '{OP_VERTEX, MODE_POINTS, 16'h0001, 1'b0, '0},
    '{OP_VERTEX, MODE_POINTS, 16'h8000, 1'b0, '0},
    '{OP_VERTEX, MODE_POINTS, 16'h7FFF, 1'b0, '0},
    '{OP_END, MODE_POINTS, 16'h0000, 1'b0, '0},
    '{OP_BEGIN, MODE_QUADS, 16'h0000, 1'b0, '0},
    '{OP_VERTEX, MODE_POINTS, 16'h0010, 1'b0, '0},
    '{OP_VERTEX, MODE_POINTS, 16'h0020, 1'b0, '0},
    '{OP_VERTEX, MODE_POINTS, 16'h0030, 1'b0, '0},
    '{OP_VERTEX, MODE_POINTS, 16'h0040, 1'b0, '0},
    '{OP_END, MODE_POINTS, 16'h0000, 1'b0, '0}
  };

  primitive_assembler_core #(
    .VERTEX_ID_BITS(VW)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .mode       (mode),
    .vertex_id  (vertex_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .prim_kind  (prim_kind),
    .vert_a     (vert_a),
    .vert_b     (vert_b),
    .vert_c     (vert_c),
    .error_code (error_code),
    .last       (last)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void add_prim(input logic [1:0] kind, input logic [VW-1:0] a,
                                   input logic [VW-1:0] b, input logic [VW-1:0] c,
                                   input logic [1:0] err);
    fresh_prims.push_back('{kind, a, b, c, err, 1'b0});
  endfunction

  function automatic void place_vertex(input logic [VW-1:0] v);
    logic [3:0] p;
    logic       first;
    logic       second;
    p = asm_phase;
    first = (p == 4'd0) && !asm_two;
    second = (p == 4'd1) && !asm_two;
    case (asm_mode)
      MODE_POINTS: begin
        add_prim(KIND_POINT, v, '0, '0, ERR_NONE);
      end
      MODE_LINES: begin
        asm_win[p[0]] = v;
        if (p[0]) add_prim(KIND_LINE, asm_win[0], asm_win[1], '0, ERR_NONE);
      end
      MODE_LINE_LOOP: begin
        if (first) asm_hub = v;
        else add_prim(KIND_LINE, asm_win[0], v, '0, ERR_NONE);
        asm_win[0] = v;
      end
      MODE_LINE_STRIP: begin
        if (!first) add_prim(KIND_LINE, asm_win[0], v, '0, ERR_NONE);
        asm_win[0] = v;
      end
      MODE_TRIANGLES: begin
        asm_win[int'(p % 4'd3)] = v;
        if (p % 4'd3 == 4'd2) begin
          add_prim(KIND_TRI, asm_win[0], asm_win[1], asm_win[2], ERR_NONE);
        end
      end
      MODE_TRI_STRIP: begin
        if (!asm_two) begin
          asm_win[p[0]] = v;
        end else begin
          if (!asm_odd) add_prim(KIND_TRI, asm_win[0], asm_win[1], v, ERR_NONE);
          else add_prim(KIND_TRI, asm_win[1], asm_win[0], v, ERR_NONE);
          asm_odd = ~asm_odd;
          asm_win[0] = asm_win[1];
          asm_win[1] = v;
        end
      end
      MODE_TRI_FAN, MODE_POLYGON: begin
        if (first) begin
          asm_hub = v;
        end else if (second) begin
          asm_win[0] = v;
        end else begin
          add_prim(KIND_TRI, asm_hub, asm_win[0], v, ERR_NONE);
          asm_win[0] = v;
        end
      end
      MODE_QUADS: begin
        asm_win[p[1:0]] = v;
        if (p[1:0] == 2'd3) begin
          add_prim(KIND_TRI, asm_win[0], asm_win[1], asm_win[2], ERR_NONE);
          add_prim(KIND_TRI, asm_win[0], asm_win[2], asm_win[3], ERR_NONE);
        end
      end
      MODE_QUAD_STRIP: begin
        if (!asm_two) begin
          asm_win[p[0]] = v;
        end else begin
          asm_win[2 + p[0]] = v;
          if (p[0]) begin
            add_prim(KIND_TRI, asm_win[0], asm_win[1], asm_win[3], ERR_NONE);
            add_prim(KIND_TRI, asm_win[0], asm_win[3], asm_win[2], ERR_NONE);
            asm_win[0] = asm_win[2];
            asm_win[1] = asm_win[3];
          end
        end
      end
      default: ;
    endcase
    if (!first) asm_two = 1'b1;
    asm_phase = (p == PHASE_LAST) ? 4'd0 : p + 4'd1;
  endfunction

  function automatic void assemble(input logic [1:0] o, input logic [3:0] m,
                                   input logic [VW-1:0] v);
    prim_t tail;
    fresh_prims.delete();
    case (o)
      OP_BEGIN: begin
        if (asm_open) begin
          add_prim(KIND_NONE, '0, '0, '0, ERR_INV_OP);
        end else if (m > MODE_POLYGON) begin
          add_prim(KIND_NONE, '0, '0, '0, ERR_INV_MODE);
        end else begin
          asm_open = 1'b1;
          asm_mode = m;
          asm_phase = '0;
          asm_two = 1'b0;
          asm_odd = 1'b0;
        end
      end
      OP_VERTEX: begin
        if (!asm_open) add_prim(KIND_NONE, '0, '0, '0, ERR_INV_OP);
        else place_vertex(v);
      end
      OP_END: begin
        if (!asm_open) begin
          add_prim(KIND_NONE, '0, '0, '0, ERR_INV_OP);
        end else begin
          if (asm_mode == MODE_LINE_LOOP && asm_two) begin
            add_prim(KIND_LINE, asm_win[0], asm_hub, '0, ERR_NONE);
          end
          asm_open = 1'b0;
          asm_phase = '0;
          asm_two = 1'b0;
        end
      end
      default: ;
    endcase
    if (fresh_prims.size() > 0) begin
      tail = fresh_prims[fresh_prims.size() - 1];
      tail.last = 1'b1;
      fresh_prims[fresh_prims.size() - 1] = tail;
    end
  endfunction

  function automatic logic [VW-1:0] pick_vid();
    logic [VW-1:0] v;
    v = VW'($urandom);
    if ($urandom_range(0, 15) == 0) v = ($urandom_range(0, 1) == 0) ? '0 : '1;
    return v;
  endfunction

  task automatic send_item(input logic [1:0] o, input logic [3:0] m,
                           input logic [VW-1:0] v, input logic typed, input prim_t want);
    int gap;
    if (tx_idles && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    mode <= m;
    vertex_id <= v;
    do @(posedge clk); while (!in_ready);
    assemble(o, m, v);
    if (typed) begin
      expected_prims.push_back(want);
    end else begin
      foreach (fresh_prims[i]) expected_prims.push_back(fresh_prims[i]);
    end
    if (o != OP_SPARE) items_sent++;
  endtask

  task automatic send_noise();
    send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), pick_vid(), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    if (rst || !rx_stalls) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    prim_t got;
    prim_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{prim_kind, vert_a, vert_b, vert_c, error_code, last};
      if (expected_prims.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d a %h b %h c %h err %0d last %0b",
                                  got.kind, got.a, got.b, got.c, got.err, got.last));
      end else begin
        want = expected_prims.pop_front();
        if (got.kind !== want.kind || got.a !== want.a || got.b !== want.b ||
            got.c !== want.c || got.err !== want.err || got.last !== want.last) begin
          report_mismatch($sformatf(
            "got kind %0d a %h b %h c %h err %0d last %0b, want %0d %h %h %h %0d %0b",
            got.kind, got.a, got.b, got.c, got.err, got.last,
            want.kind, want.a, want.b, want.c, want.err, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n_vert;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].op, dir_rows[i].mode, dir_rows[i].vid,
                dir_rows[i].typed, dir_rows[i].want);
    end

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= CALM_FROM) begin
        tx_idles <= 1'b0;
        rx_stalls <= 1'b0;
      end else if ($urandom_range(0, 24) == 0) begin
        tx_idles <= ($urandom_range(0, 2) != 0);
        rx_stalls <= ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 99) < 12) begin
        send_noise();
      end else begin
        if (asm_open) send_item(OP_END, 4'($urandom_range(0, 15)), pick_vid(), 1'b0, '0);
        send_item(OP_BEGIN, 4'($urandom_range(0, 9)), pick_vid(), 1'b0, '0);
        n_vert = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
        for (int k = 0; k < n_vert; k++) begin
          if ($urandom_range(0, 29) == 0) begin
            send_item(($urandom_range(0, 1) == 0) ? OP_BEGIN : OP_SPARE,
                      4'($urandom_range(0, 15)), pick_vid(), 1'b0, '0);
          end
          send_item(OP_VERTEX, 4'($urandom_range(0, 15)), pick_vid(), 1'b0, '0);
        end
        if ($urandom_range(0, 19) != 0) begin
          send_item(OP_END, 4'($urandom_range(0, 15)), pick_vid(), 1'b0, '0);
        end
      end
    end
    in_valid <= 1'b0;

    while (expected_prims.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/prim_asm_pkg.sv
rtl/prim_asm_fifo.sv
rtl/prim_asm_front.sv
rtl/prim_asm_back.sv
rtl/primitive_assembler_core.sv
tb/primitive_assembler_core_tb.sv
